// ----- design/fvasp_pkg.sv -----
package fvasp_pkg;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  cmd_byte;
      logic [17:0] load_addr;
      logic [7:0]  rom_byte;
   } req_type;

   typedef struct packed {
      logic signed [17:0] mix_sample;
      logic [3:0]         playing_mask;
   } rsp_type;

   localparam logic [1:0] OP_CMD    = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_LOAD   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int          NUM_VOICES = 4;
   localparam logic [5:0]  MAX_INDEX  = 6'd48;
   localparam logic [17:0] ADDR_MASK  = 18'h3FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_ADDR,
      ST_RD_WAIT,
      ST_RD_TAKE,
      ST_START,
      ST_V_CHECK,
      ST_V_WAIT,
      ST_V_STEP,
      ST_V_SIG,
      ST_V_MUL,
      ST_SUM,
      ST_DONE
   } state_type;

   function automatic logic [10:0] step_of(input logic [5:0] idx);
      logic [10:0] s;
      begin
         unique case (idx)
            6'd0: s = 11'd16;    6'd1: s = 11'd17;    6'd2: s = 11'd19;
            6'd3: s = 11'd21;    6'd4: s = 11'd23;    6'd5: s = 11'd25;
            6'd6: s = 11'd28;    6'd7: s = 11'd31;    6'd8: s = 11'd34;
            6'd9: s = 11'd37;    6'd10: s = 11'd41;   6'd11: s = 11'd45;
            6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
            6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
            6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
            6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
            6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
            6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
            6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
            6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
            6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
            6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
            6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
            6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
            default: s = 11'd1552;
         endcase
         return s;
      end
   endfunction

   function automatic logic [5:0] gain_of(input logic [3:0] code);
      logic [5:0] g;
      begin
         unique case (code)
            4'd0: g = 6'd32; 4'd1: g = 6'd22; 4'd2: g = 6'd16;
            4'd3: g = 6'd11; 4'd4: g = 6'd8;  4'd5: g = 6'd6;
            4'd6: g = 6'd4;  4'd7: g = 6'd3;  4'd8: g = 6'd2;
            default: g = 6'd0;
         endcase
         return g;
      end
   endfunction

   function automatic logic signed [4:0] index_shift(input logic [2:0] c);
      logic signed [4:0] d;
      begin
         unique case (c)
            3'd4: d = 5'sd2;
            3'd5: d = 5'sd4;
            3'd6: d = 5'sd6;
            3'd7: d = 5'sd8;
            default: d = -5'sd1;
         endcase
         return d;
      end
   endfunction

endpackage

// ----- design/fvasp_rom.sv -----
module fvasp_rom #(
   parameter int ROM_ADDR_BITS = 18
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ROM_ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [ROM_ADDR_BITS-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   localparam int DEPTH = 1 << ROM_ADDR_BITS;

   logic [7:0] mem [DEPTH];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- design/four_voice_adpcm_sample_player_top.sv -----
// four-voice adpcm sample player
// request channel: req_data is taken at a rising edge where start is high and
// busy is low. op 0 writes a command byte, op 1 is a sample tick, op 2 loads
// one byte into the sample memory (addresses beyond the memory are dropped).
// every request yields exactly one response: rsp_valid pulses high for one
// cycle with the voice mix and the playing mask; the receiver cannot stall.
// sequence, from the accepting edge to the response:
//   load, stop, phrase latch and unused op: sum and done states only
//   voice-select byte: voices in turn; one that is named and not playing
//   reads six phrase table bytes, each through address, wait and take states
//   tick: voices in turn; an idle or ending voice is only checked, a decoding
//   voice goes through the check, wait, step, signal and multiply states
// busy stays high until the response cycle, so the next request can be taken
// at the edge that ends it. one memory read port and one multiplier are
// shared by all voices in turn.
// reset (synchronous, active high) idles every voice and clears the outputs;
// the sample memory holds no reset value and must be loaded before use.
module four_voice_adpcm_sample_player_top #(
   parameter int ROM_ADDR_BITS = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fvasp_pkg::req_type req_data,
   output logic              rsp_valid,
   output fvasp_pkg::rsp_type rsp_data
);
   import fvasp_pkg::*;

   localparam int NV = NUM_VOICES;

   // request and sequencer registers
   req_type     req_ff, req_in;
   state_type   state_ff, state_in;
   logic [1:0]  vox_ff, vox_in;
   logic [2:0]  byte_ff, byte_in;
   logic [17:0] start_ff, start_in;
   logic [17:0] stop_ff, stop_in;
   logic [9:0]  acc_ff, acc_in;
   logic signed [12:0] delta_ff, delta_in;

   logic        pend_ff, pend_in;
   logic [6:0]  phrase_ff, phrase_in;

   logic [NV-1:0]  play_ff, play_in;
   logic [17:0]    addr_ff [NV];
   logic [17:0]    addr_in [NV];
   logic [17:0]    vstop_ff [NV];
   logic [17:0]    vstop_in [NV];
   logic [7:0]     vbyte_ff [NV];
   logic [7:0]     vbyte_in [NV];
   logic [NV-1:0]  high_ff, high_in;
   logic [5:0]     idx_ff [NV];
   logic [5:0]     idx_in [NV];
   logic signed [11:0] sig_ff [NV];
   logic signed [11:0] sig_in [NV];
   logic [5:0]     gain_ff [NV];
   logic [5:0]     gain_in [NV];
   logic signed [16:0] out_ff [NV];
   logic signed [16:0] out_in [NV];

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // memory port
   logic                     rom_wr;
   logic [ROM_ADDR_BITS-1:0] rom_waddr;
   logic [ROM_ADDR_BITS-1:0] rom_raddr;
   logic [7:0]               rom_rdata;
   logic [17:0]              rd_addr;
   logic                     rd_oob_ff, rd_oob_in;
   logic [7:0]               rd_byte;

   fvasp_rom #(.ROM_ADDR_BITS(ROM_ADDR_BITS)) u_rom (
      .clock   (clock),
      .wr_en   (rom_wr),
      .wr_addr (rom_waddr),
      .wr_data (req_ff.rom_byte),
      .rd_addr (rom_raddr),
      .rd_data (rom_rdata)
   );

   // in-range check on 18-bit addresses against the memory size
   function automatic logic in_range(input logic [17:0] a);
      logic ok;
      begin
         ok = 1'b1;
         for (int b = ROM_ADDR_BITS; b < 18; b++) begin
            if (a[b]) ok = 1'b0;
         end
         return ok;
      end
   endfunction

   assign rom_waddr = ROM_ADDR_BITS'(req_ff.load_addr);
   assign rom_raddr = ROM_ADDR_BITS'(rd_addr);
   assign rd_byte   = rd_oob_ff ? 8'd0 : rom_rdata;

   // shared arithmetic: current voice step and code
   logic [3:0]  code;
   logic [10:0] step;
   logic [12:0] mag;
   logic signed [13:0] sum_sig;
   logic signed [6:0]  idx_sum;
   logic signed [17:0] mul_p;
   logic [20:0] phr_base;
   logic        vox_named;
   logic        last_vox;

   always_comb begin
      code = high_ff[vox_ff] ? rd_byte[7:4] : vbyte_ff[vox_ff][3:0];
      step = step_of(idx_ff[vox_ff]);
      mag  = 13'(step >> 3);
      if (code[0]) mag = mag + 13'(step >> 2);
      if (code[1]) mag = mag + 13'(step >> 1);
      if (code[2]) mag = mag + 13'(step);
      sum_sig = 14'(sig_ff[vox_ff]) + 14'(delta_ff);
      idx_sum = $signed({1'b0, idx_ff[vox_ff]}) + 7'(index_shift(code[2:0]));
      mul_p   = 18'(sig_ff[vox_ff]) * $signed({12'd0, gain_ff[vox_ff]});
      phr_base = {11'd0, phrase_ff, 3'd0};
      vox_named = req_ff.cmd_byte[3'd4 + 3'(vox_ff)] && !play_ff[vox_ff];
      last_vox  = (vox_ff == 2'(NV-1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority if (req_data.op == OP_TICK) begin
                  state_in = ST_V_CHECK;
               end else if (req_data.op == OP_CMD && pend_ff) begin
                  state_in = ST_RD_ADDR;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_RD_ADDR: state_in = vox_named ? ST_RD_WAIT : ST_START;
         ST_RD_WAIT: state_in = ST_RD_TAKE;
         ST_RD_TAKE: state_in = (byte_ff == 3'd5) ? ST_START : ST_RD_ADDR;
         ST_START:   state_in = last_vox ? ST_SUM : ST_RD_ADDR;
         ST_V_CHECK: begin
            if (!play_ff[vox_ff] || (addr_ff[vox_ff] == vstop_ff[vox_ff])) begin
               state_in = last_vox ? ST_SUM : ST_V_CHECK;
            end else begin
               state_in = ST_V_WAIT;
            end
         end
         ST_V_WAIT:  state_in = ST_V_STEP;
         ST_V_STEP:  state_in = ST_V_SIG;
         ST_V_SIG:   state_in = ST_V_MUL;
         ST_V_MUL:   state_in = last_vox ? ST_SUM : ST_V_CHECK;
         ST_SUM:     state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and sequencer outputs
   always_comb begin
      req_in     = req_ff;
      vox_in     = vox_ff;
      byte_in    = byte_ff;
      start_in   = start_ff;
      stop_in    = stop_ff;
      acc_in     = acc_ff;
      delta_in   = delta_ff;
      pend_in    = pend_ff;
      phrase_in  = phrase_ff;
      play_in    = play_ff;
      high_in    = high_ff;
      addr_in    = addr_ff;
      vstop_in   = vstop_ff;
      vbyte_in   = vbyte_ff;
      idx_in     = idx_ff;
      sig_in     = sig_ff;
      gain_in    = gain_ff;
      out_in     = out_ff;
      rsp_valid_in = 1'b0;
      rsp_in     = rsp_ff;
      rom_wr     = 1'b0;
      rd_addr    = 18'd0;
      rd_oob_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in  = req_data;
               vox_in  = 2'd0;
               byte_in = 3'd0;
            end
         end
         // phrase table read for voice vox_ff, address held through the wait
         ST_RD_ADDR, ST_RD_WAIT: begin
            rd_addr   = 18'(phr_base + 21'(byte_ff));
            rd_oob_in = !in_range(rd_addr);
         end
         ST_RD_TAKE: begin
            acc_in = {acc_ff[1:0], rd_byte};
            if (byte_ff == 3'd2) start_in = {acc_ff[9:0], rd_byte};
            if (byte_ff == 3'd5) stop_in  = {acc_ff[9:0], rd_byte};
            byte_in = (byte_ff == 3'd5) ? 3'd0 : byte_ff + 3'd1;
         end
         ST_START: begin
            if (vox_named && (start_ff < stop_ff)) begin
               play_in[vox_ff]  = 1'b1;
               addr_in[vox_ff]  = start_ff;
               vstop_in[vox_ff] = stop_ff;
               gain_in[vox_ff]  = gain_of(req_ff.cmd_byte[3:0]);
               vbyte_in[vox_ff] = 8'd0;
               high_in[vox_ff]  = 1'b1;
               idx_in[vox_ff]   = 6'd0;
               sig_in[vox_ff]   = 12'sd0;
            end
            byte_in = 3'd0;
            vox_in  = vox_ff + 2'd1;
         end
         // tick: one voice at a time, sample address held through the wait
         ST_V_CHECK: begin
            rd_addr   = addr_ff[vox_ff];
            rd_oob_in = !in_range(rd_addr);
            if (!play_ff[vox_ff]) begin
               vox_in = vox_ff + 2'd1;
            end else if (addr_ff[vox_ff] == vstop_ff[vox_ff]) begin
               play_in[vox_ff] = 1'b0;
               vox_in = vox_ff + 2'd1;
            end
         end
         ST_V_WAIT: begin
            rd_addr   = addr_ff[vox_ff];
            rd_oob_in = !in_range(rd_addr);
         end
         ST_V_STEP: begin
            if (high_ff[vox_ff]) begin
               vbyte_in[vox_ff] = rd_byte;
               addr_in[vox_ff]  = (addr_ff[vox_ff] + 18'd1) & ADDR_MASK;
            end
            high_in[vox_ff] = !high_ff[vox_ff];
            delta_in = code[3] ? -$signed(mag) : $signed(mag);
            if (idx_sum < 7'sd0) idx_in[vox_ff] = 6'd0;
            else if (idx_sum > $signed({1'b0, MAX_INDEX})) idx_in[vox_ff] = MAX_INDEX;
            else idx_in[vox_ff] = 6'(idx_sum);
         end
         ST_V_SIG: begin
            if (sum_sig < -14'sd2048) sig_in[vox_ff] = -12'sd2048;
            else if (sum_sig > 14'sd2047) sig_in[vox_ff] = 12'sd2047;
            else sig_in[vox_ff] = 12'(sum_sig);
         end
         ST_V_MUL: begin
            // finish voice: halve toward zero
            out_in[vox_ff] = 17'((mul_p + 18'(mul_p[17])) >>> 1);
            vox_in = vox_ff + 2'd1;
         end
         ST_SUM: begin
            if (req_ff.op == OP_LOAD && in_range(req_ff.load_addr)) rom_wr = 1'b1;
            if (req_ff.op == OP_CMD) begin
               if (pend_ff) begin
                  pend_in = 1'b0;
               end else if (req_ff.cmd_byte[7]) begin
                  phrase_in = req_ff.cmd_byte[6:0];
                  pend_in = 1'b1;
               end else begin
                  for (int i = 0; i < NV; i++) begin
                     if (req_ff.cmd_byte[3+i]) play_in[i] = 1'b0;
                  end
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.mix_sample = 18'(out_ff[0]) + 18'(out_ff[1])
                              + 18'(out_ff[2]) + 18'(out_ff[3]);
            rsp_in.playing_mask = play_ff;
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         phrase_ff    <= 7'd0;
         play_ff      <= '0;
         high_ff      <= '1;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
         for (int i = 0; i < NV; i++) begin
            addr_ff[i]  <= 18'd0;
            vstop_ff[i] <= 18'd0;
            vbyte_ff[i] <= 8'd0;
            idx_ff[i]   <= 6'd0;
            sig_ff[i]   <= 12'sd0;
            gain_ff[i]  <= 6'd0;
            out_ff[i]   <= 17'sd0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         phrase_ff    <= phrase_in;
         play_ff      <= play_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
         addr_ff      <= addr_in;
         vstop_ff     <= vstop_in;
         vbyte_ff     <= vbyte_in;
         idx_ff       <= idx_in;
         sig_ff       <= sig_in;
         gain_ff      <= gain_in;
         out_ff       <= out_in;
      end
      req_ff    <= req_in;
      vox_ff    <= vox_in;
      byte_ff   <= byte_in;
      start_ff  <= start_in;
      stop_ff   <= stop_in;
      acc_ff    <= acc_in;
      delta_ff  <= delta_in;
      rd_oob_ff <= rd_oob_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
